// File: sv/mvp_pkg.sv
// Shared types and constants of the vertex transform.
package mvp_pkg;

    // Number format: signed words with FRAC_BITS fraction bits.
    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int TRUNC_W   = PROD_W - FRAC_BITS;
    // Four truncated products add up without overflow in two extra bits.
    localparam int ACC_W     = TRUNC_W + 2;

    // Matrix geometry and coefficient store layout.
    localparam int DIM         = 4;
    localparam int IDX_W       = 2;
    localparam int SEL_W       = 2;
    localparam int ADDR_W      = SEL_W + 2 * IDX_W;
    localparam int MAT_COUNT   = 3;
    localparam int TABLE_DEPTH = MAT_COUNT * DIM * DIM;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

    // Item codes.
    localparam logic CMD_TRANSFORM = 1'b0;
    localparam logic CMD_LOAD      = 1'b1;

    // Matrix select codes.
    localparam logic [SEL_W-1:0] MAT_WORLD  = 2'd0;
    localparam logic [SEL_W-1:0] MAT_VIEW   = 2'd1;
    localparam logic [SEL_W-1:0] MAT_PROJ   = 2'd2;
    localparam logic [SEL_W-1:0] MAT_UNUSED = 2'd3;

    // The constant 1.0 used as the w component of every input position.
    localparam logic signed [WORD_W-1:0] ONE_Q = WORD_W'(64'd1 << FRAC_BITS);
    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Input transaction payload.
    typedef struct packed {
        logic                     command;
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
        logic        [WORD_W-1:0] vertex_color;
        logic        [SEL_W-1:0]  matrix_select;
        logic        [IDX_W-1:0]  coef_row;
        logic        [IDX_W-1:0]  coef_col;
        logic signed [WORD_W-1:0] coef_value;
    } t_vtx_in;

    // Result transaction payload.
    typedef struct packed {
        logic signed [WORD_W-1:0] out_x;
        logic signed [WORD_W-1:0] out_y;
        logic signed [WORD_W-1:0] out_z;
        logic signed [WORD_W-1:0] out_w;
        logic        [WORD_W-1:0] out_color;
        logic                     saturated;
    } t_vtx_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             vtx_load;
        logic             coef_wr;
        logic             mac_vld;
        logic [SEL_W-1:0] mac_sel;
        logic [IDX_W-1:0] mac_k;
        logic [IDX_W-1:0] mac_j;
        logic             commit;
        logic             out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

// File: sv/mvp_if.sv
// Valid/ready channel interfaces for input and result transactions.
interface mvp_in_if;
    import mvp_pkg::*;

    logic    valid;
    logic    ready;
    t_vtx_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mvp_out_if;
    import mvp_pkg::*;

    logic     valid;
    logic     ready;
    t_vtx_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/vertex_world_view_proj_transform.sv
// Vertex transform top level: position times world, view and projection matrices.
//
// A load transaction writes one signed Q16.16 coefficient into the world, view or
// projection matrix; a load with matrix select 3 is ignored. All coefficients
// read as zero after reset without any clearing pass. A transform transaction
// multiplies (x, y, z, 1.0) by world, then view, then projection and gives one
// result: after it is accepted, each of the three matrices sends 16 products
// through the single shared 32x32 multiplier (one per cycle) and then lets the
// multiply-accumulate pipeline drain before the next matrix can use the new
// vector, and the final vector goes into the result register. Each product is
// truncated toward minus infinity, each column sum is saturated to 32 bits, and
// the saturated flag reports any saturation in the vertex. The color passes
// through unchanged. A finished result waits in the output register, and new
// load and transform transactions are taken while it waits.
module vertex_world_view_proj_transform (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mvp_in_if.sink    i_vtx,
    mvp_out_if.source o_res
);
    import mvp_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer.
    mvp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_vtx.valid),
        .i_in_command (i_vtx.payload.command),
        .o_in_ready   (i_vtx.ready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    // Arithmetic and storage.
    mvp_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_vtx        (i_vtx.payload),
        .i_out_ready  (o_res.ready),
        .o_out_valid  (o_res.valid),
        .o_out        (o_res.payload),
        .o_stat       (w_stat)
    );

endmodule

// File: sv/mvp_ctrl.sv
// Controller state machine that sequences the multiply-accumulate steps.
module mvp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_command,
    output logic              o_in_ready,
    input  mvp_pkg::t_dp_stat i_stat,
    output mvp_pkg::t_dp_cmd  o_cmd
);
    import mvp_pkg::*;

    localparam logic [1:0] DRAIN_LAST = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [SEL_W-1:0] r_sel, n_sel;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_j, n_j;
    logic [1:0]       r_drain, n_drain;
    logic             w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state: 16 products per matrix, then a drain of the datapath pipeline.
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_k     = r_k;
        n_j     = r_j;
        n_drain = r_drain;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_in_command == CMD_TRANSFORM) begin
                    n_state = S_MAC;
                    n_sel   = MAT_WORLD;
                    n_k     = '0;
                    n_j     = '0;
                end
            end
            S_MAC: begin
                n_k = r_k + 1'b1;
                if (r_k == IDX_LAST) begin
                    n_j = r_j + 1'b1;
                    if (r_j == IDX_LAST) begin
                        n_state = S_DRAIN;
                        n_drain = '0;
                    end
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == DRAIN_LAST) begin
                    if (r_sel == MAT_PROJ) begin
                        n_state = S_DONE;
                    end else begin
                        n_sel   = r_sel + 1'b1;
                        n_state = S_MAC;
                    end
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands decoded from the current state and the input handshake.
    always_comb begin
        o_cmd.vtx_load = w_accept && (i_in_command == CMD_TRANSFORM);
        o_cmd.coef_wr  = w_accept && (i_in_command == CMD_LOAD);
        o_cmd.mac_vld  = (r_state == S_MAC);
        o_cmd.mac_sel  = r_sel;
        o_cmd.mac_k    = r_k;
        o_cmd.mac_j    = r_j;
        o_cmd.commit   = (r_state == S_DRAIN) && (r_drain == DRAIN_LAST);
        o_cmd.out_load = (r_state == S_DONE) && !i_stat.out_busy;
    end

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= MAT_WORLD;
            r_k     <= '0;
            r_j     <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_k     <= n_k;
            r_j     <= n_j;
            r_drain <= n_drain;
        end
    end

`ifndef ASSERT_OFF
    // An accepted vertex starts with the world matrix.
    a_start_world: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_command == CMD_TRANSFORM) |=> (r_state == S_MAC && r_sel == MAT_WORLD))
        else $error("vertex did not start with the world matrix");

    // The result is only presented after the projection matrix has drained.
    a_done_after_proj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && $past(r_state) != S_DONE) |->
            ($past(r_state) == S_DRAIN && $past(r_sel) == MAT_PROJ))
        else $error("result presented before the projection stage finished");

    // A matrix pass always issues from the first product of the first column.
    a_mac_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC && $past(r_state) != S_MAC) |-> (r_k == '0 && r_j == '0))
        else $error("matrix pass entered mid-sequence");
`endif

endmodule

// File: sv/mvp_datapath.sv
// Datapath: coefficient store, shared multiply-accumulate and result register.
module mvp_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mvp_pkg::t_dp_cmd  i_cmd,
    input  mvp_pkg::t_vtx_in  i_vtx,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output mvp_pkg::t_vtx_out o_out,
    output mvp_pkg::t_dp_stat o_stat
);
    import mvp_pkg::*;

    // Coefficient store with one valid bit per entry; unwritten entries read as zero.
    logic        [WORD_W-1:0]      mem [TABLE_DEPTH];
    logic        [TABLE_DEPTH-1:0] r_coef_vld;
    logic        [ADDR_W-1:0]      w_wr_addr;
    logic        [ADDR_W-1:0]      w_rd_addr;
    logic                          w_wr_en;

    // Multiply-accumulate pipeline.
    logic        [WORD_W-1:0]      r_coef;
    logic                          r_coef_ok;
    logic signed [WORD_W-1:0]      r_opnd;
    logic signed [WORD_W-1:0]      w_coef_eff;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       w_trunc_ext;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          w_fits;
    logic signed [WORD_W-1:0]      w_sat_val;

    // Pipeline tags.
    logic                          r_p1_vld, r_p2_vld, r_p3_vld;
    logic                          r_p1_first, r_p2_first;
    logic                          r_p1_last, r_p2_last;
    logic        [IDX_W-1:0]       r_p1_j, r_p2_j, r_p3_j;

    // Vertex state.
    logic signed [WORD_W-1:0]      r_vec [DIM];
    logic signed [WORD_W-1:0]      r_res [DIM];
    logic        [WORD_W-1:0]      r_color;
    logic                          r_sat;

    // Result register.
    logic                          r_out_vld;
    t_vtx_out                      r_out;

    assign w_wr_addr = {i_vtx.matrix_select, i_vtx.coef_row, i_vtx.coef_col};
    assign w_rd_addr = {i_cmd.mac_sel, i_cmd.mac_k, i_cmd.mac_j};
    assign w_wr_en   = i_cmd.coef_wr && (i_vtx.matrix_select != MAT_UNUSED);

    // Store write and registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= i_vtx.coef_value;
        end
        r_coef <= mem[w_rd_addr];
    end

    // Valid bits are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
        end else if (w_wr_en) begin
            r_coef_vld[w_wr_addr] <= 1'b1;
        end
    end

    // Product: floor-truncate to the working format and sign extend.
    assign w_coef_eff  = r_coef_ok ? signed'(r_coef) : '0;
    assign w_trunc_ext = {{(ACC_W-TRUNC_W){r_prod[PROD_W-1]}}, r_prod[PROD_W-1:FRAC_BITS]};

    // Saturate the column sum to the signed word range.
    assign w_fits    = (&r_acc[ACC_W-1:WORD_W-1]) || !(|r_acc[ACC_W-1:WORD_W-1]);
    assign w_sat_val = w_fits ? r_acc[WORD_W-1:0] : (r_acc[ACC_W-1] ? WORD_MIN : WORD_MAX);

    // Pipeline control tags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_cmd.mac_vld;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld && r_p2_last;
        end
    end

    // Multiply-accumulate payload path.
    always_ff @(posedge i_clk) begin
        r_coef_ok  <= r_coef_vld[w_rd_addr];
        r_opnd     <= r_vec[i_cmd.mac_k];
        r_p1_first <= (i_cmd.mac_k == '0);
        r_p1_last  <= (i_cmd.mac_k == IDX_LAST);
        r_p1_j     <= i_cmd.mac_j;
        r_prod     <= w_coef_eff * r_opnd;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_j     <= r_p1_j;
        r_p3_j     <= r_p2_j;
        if (r_p2_vld) begin
            r_acc <= r_p2_first ? w_trunc_ext : r_acc + w_trunc_ext;
        end
        if (r_p3_vld) begin
            r_res[r_p3_j] <= w_sat_val;
        end
    end

    // Vertex vector, color and overflow flag.
    always_ff @(posedge i_clk) begin
        if (i_cmd.vtx_load) begin
            r_vec[0] <= i_vtx.pos_x;
            r_vec[1] <= i_vtx.pos_y;
            r_vec[2] <= i_vtx.pos_z;
            r_vec[3] <= ONE_Q;
            r_color  <= i_vtx.vertex_color;
        end else if (i_cmd.commit) begin
            r_vec <= r_res;
        end
        if (i_cmd.vtx_load) begin
            r_sat <= 1'b0;
        end else if (r_p3_vld && !w_fits) begin
            r_sat <= 1'b1;
        end
    end

    // Result register: holds a finished transaction until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.out_x     <= r_vec[0];
            r_out.out_y     <= r_vec[1];
            r_out.out_z     <= r_vec[2];
            r_out.out_w     <= r_vec[3];
            r_out.out_color <= r_color;
            r_out.saturated <= r_sat;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_out           = r_out;
    assign o_stat.out_busy = r_out_vld && !i_out_ready;

`ifndef ASSERT_OFF
    // The last column sum must be saturated before the stage result is committed.
    a_commit_after_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_p3_vld && !r_p2_vld && !r_p1_vld))
        else $error("stage committed while products are still in flight");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_vld && !i_out_ready))
        else $error("result register overwritten before it was taken");

    // Coefficient loads never overlap a matrix pass.
    a_no_wr_during_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.coef_wr && (i_cmd.mac_vld || r_p1_vld || r_p2_vld)))
        else $error("coefficient written during a matrix pass");
`endif

endmodule

// File: tb/sv/vertex_world_view_proj_transform_test.sv
// Self-checking testbench for the world-view-projection vertex transform.
module vertex_world_view_proj_transform_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mvp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned PHASE_ITEMS  = 360;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned TAIL_CYCLES  = 100;
    localparam int unsigned MAX_REPORTS  = 60;
    // Random positions are mostly within +/-256.0 and whole-matrix rewrites stay within +/-2.0.
    localparam int unsigned POS_SPAN     = 256 << FRAC_BITS;
    localparam int unsigned COEF_SPAN    = 2 << FRAC_BITS;

    // One row of the directed table: the transaction and, optionally, its known result.
    typedef struct {
        t_vtx_in  item;
        bit       typed;
        t_vtx_out result;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mvp_in_if  vtx_ch ();
    mvp_out_if res_ch ();

    vertex_world_view_proj_transform dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx_ch),
        .o_res   (res_ch)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the coefficient store and the results still to arrive.
    logic signed [WORD_W-1:0] coef_store [TABLE_DEPTH];
    t_vtx_out                 pending_results [$];
    t_dir_row                 directed [$];

    // Side information that travels with the transaction being offered.
    bit          typed_on;
    t_vtx_out    typed_res;

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned hold_left;
    int unsigned cycle_count;

    int unsigned n_transforms;
    int unsigned n_loads;
    int unsigned n_ignored;
    int unsigned n_checked;
    int unsigned n_saturated;
    int unsigned n_mismatch;

    t_vtx_out predicted;

    // Apply a load transaction to the local coefficient store.
    function automatic void store_coef(t_vtx_in it);
        if (it.matrix_select != MAT_UNUSED) begin
            coef_store[int'(it.matrix_select) * DIM * DIM + int'(it.coef_row) * DIM
                       + int'(it.coef_col)] = it.coef_value;
            n_loads++;
        end else begin
            n_ignored++;
        end
    endfunction

    // Position (x, y, z, 1.0) through world, view and projection, saturating each column sum.
    function automatic t_vtx_out transform_vertex(t_vtx_in it);
        longint   vec [DIM];
        longint   col_sum [DIM];
        t_vtx_out r;
        r      = '0;
        vec[0] = longint'(it.pos_x);
        vec[1] = longint'(it.pos_y);
        vec[2] = longint'(it.pos_z);
        vec[3] = longint'(ONE_Q);
        for (int m = 0; m < MAT_COUNT; m++) begin
            for (int j = 0; j < DIM; j++) begin
                col_sum[j] = 0;
                // Each product is floored to the fixed-point grid before summing.
                for (int k = 0; k < DIM; k++)
                    col_sum[j] += (longint'(coef_store[m * DIM * DIM + k * DIM + j]) * vec[k])
                                  >>> FRAC_BITS;
                if (col_sum[j] > longint'(WORD_MAX)) begin
                    col_sum[j]  = longint'(WORD_MAX);
                    r.saturated = 1'b1;
                end else if (col_sum[j] < longint'(WORD_MIN)) begin
                    col_sum[j]  = longint'(WORD_MIN);
                    r.saturated = 1'b1;
                end
            end
            vec = col_sum;
        end
        r.out_x     = WORD_W'(vec[0]);
        r.out_y     = WORD_W'(vec[1]);
        r.out_z     = WORD_W'(vec[2]);
        r.out_w     = WORD_W'(vec[3]);
        r.out_color = it.vertex_color;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [WORD_W-1:0] expv,
                                          logic [WORD_W-1:0] gotv);
        if (gotv !== expv) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
                $error("%s: expected %h, got %h", name, expv, gotv);
        end
    endfunction

    // Compare one delivered result with the oldest outstanding prediction.
    function automatic void check_result(t_vtx_out got);
        t_vtx_out expv;
        if (pending_results.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
                $error("result transaction with no transform outstanding: %h", got);
            return;
        end
        expv = pending_results.pop_front();
        n_checked++;
        if (expv.saturated)
            n_saturated++;
        compare_field("out_x", expv.out_x, got.out_x);
        compare_field("out_y", expv.out_y, got.out_y);
        compare_field("out_z", expv.out_z, got.out_z);
        compare_field("out_w", expv.out_w, got.out_w);
        compare_field("out_color", expv.out_color, got.out_color);
        compare_field("saturated", WORD_W'(expv.saturated), WORD_W'(got.saturated));
    endfunction

    // Random word: mostly within +/-span, sometimes extremes or any bit pattern.
    function automatic logic signed [WORD_W-1:0] rand_word(int unsigned span);
        case ($urandom_range(19))
            0: return WORD_W'($urandom);
            1: begin
                case ($urandom_range(3))
                    0: return WORD_MAX;
                    1: return WORD_MIN;
                    2: return '0;
                    default: return -ONE_Q;
                endcase
            end
            2: return ONE_Q;
            default: return WORD_W'(int'($urandom_range(2 * span)) - int'(span));
        endcase
    endfunction

    // Load transaction; the position and color fields carry junk that must be ignored.
    function automatic t_vtx_in mk_load(logic [SEL_W-1:0] sel, logic [IDX_W-1:0] row,
                                        logic [IDX_W-1:0] col, logic signed [WORD_W-1:0] val);
        t_vtx_in it;
        it.command       = CMD_LOAD;
        it.pos_x         = WORD_W'($urandom);
        it.pos_y         = WORD_W'($urandom);
        it.pos_z         = WORD_W'($urandom);
        it.vertex_color  = WORD_W'($urandom);
        it.matrix_select = sel;
        it.coef_row      = row;
        it.coef_col      = col;
        it.coef_value    = val;
        return it;
    endfunction

    // Transform transaction; the coefficient fields carry junk that must be ignored.
    function automatic t_vtx_in mk_xform(logic signed [WORD_W-1:0] x,
                                         logic signed [WORD_W-1:0] y,
                                         logic signed [WORD_W-1:0] z,
                                         logic [WORD_W-1:0] color);
        t_vtx_in it;
        it.command       = CMD_TRANSFORM;
        it.pos_x         = x;
        it.pos_y         = y;
        it.pos_z         = z;
        it.vertex_color  = color;
        it.matrix_select = SEL_W'($urandom);
        it.coef_row      = IDX_W'($urandom);
        it.coef_col      = IDX_W'($urandom);
        it.coef_value    = WORD_W'($urandom);
        return it;
    endfunction

    function automatic t_vtx_out mk_res(logic signed [WORD_W-1:0] x,
                                        logic signed [WORD_W-1:0] y,
                                        logic signed [WORD_W-1:0] z,
                                        logic signed [WORD_W-1:0] w,
                                        logic [WORD_W-1:0] color, logic sat);
        t_vtx_out r;
        r.out_x     = x;
        r.out_y     = y;
        r.out_z     = z;
        r.out_w     = w;
        r.out_color = color;
        r.saturated = sat;
        return r;
    endfunction

    // Offer one transaction at a falling edge, with random idle cycles first.
    task automatic drive_item(t_vtx_in it, bit typed = 1'b0, t_vtx_out res = '0);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            vtx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        vtx_ch.valid   <= 1'b1;
        vtx_ch.payload <= it;
        typed_on  = typed;
        typed_res = res;
        do
            @(posedge i_clk);
        while (!vtx_ch.ready);
    endtask

    // Stop offering and wait until every predicted result has been delivered.
    task automatic drain_results();
        @(negedge i_clk);
        vtx_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Random traffic: whole-matrix rewrites, single loads, ignored loads and transforms.
    task automatic run_random(int unsigned n_items);
        int unsigned      sent;
        int unsigned      pick;
        logic [SEL_W-1:0] sel;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                sel = SEL_W'($urandom_range(MAT_COUNT - 1));
                for (int r = 0; r < DIM; r++)
                    for (int c = 0; c < DIM; c++)
                        drive_item(mk_load(sel, IDX_W'(r), IDX_W'(c),
                                   WORD_W'(int'($urandom_range(2 * COEF_SPAN))
                                           - int'(COEF_SPAN))));
                sent += DIM * DIM;
            end else if (pick < 40) begin
                drive_item(mk_load(SEL_W'($urandom_range(MAT_COUNT - 1)), IDX_W'($urandom),
                                   IDX_W'($urandom), rand_word(COEF_SPAN)));
                sent++;
            end else if (pick < 44) begin
                drive_item(mk_load(MAT_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                                   WORD_W'($urandom)));
            end else begin
                drive_item(mk_xform(rand_word(POS_SPAN), rand_word(POS_SPAN),
                                    rand_word(POS_SPAN), WORD_W'($urandom)));
                sent++;
            end
        end
    endtask

    // Result ready: long hold-off on request, otherwise random stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor both channels at the rising edge: check results, then predict new ones.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready)
                check_result(res_ch.payload);
            if (vtx_ch.valid && vtx_ch.ready) begin
                if (vtx_ch.payload.command == CMD_LOAD) begin
                    store_coef(vtx_ch.payload);
                end else begin
                    predicted = transform_vertex(vtx_ch.payload);
                    pending_results.push_back(typed_on ? typed_res : predicted);
                    n_transforms++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        vtx_ch.valid   = 1'b0;
        vtx_ch.payload = '0;
        res_ch.ready   = 1'b0;
        typed_on       = 1'b0;
        typed_res      = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        hold_left      = 0;
        cycle_count    = 0;
        n_transforms   = 0;
        n_loads        = 0;
        n_ignored      = 0;
        n_checked      = 0;
        n_saturated    = 0;
        n_mismatch     = 0;
        foreach (coef_store[i])
            coef_store[i] = '0;

        // Directed table. After reset every matrix is zero, so only the color survives.
        directed.push_back('{mk_xform(WORD_MAX, WORD_MIN, '0, 32'hFFFF_FFFF), 1'b1,
                             mk_res('0, '0, '0, '0, 32'hFFFF_FFFF, 1'b0)});
        // A load to the unused select must leave every matrix untouched.
        directed.push_back('{mk_load(MAT_UNUSED, IDX_LAST, IDX_LAST, WORD_MAX), 1'b0, '0});
        directed.push_back('{mk_xform(ONE_Q, ONE_Q, ONE_Q, 32'h0000_0000), 1'b1,
                             mk_res('0, '0, '0, '0, 32'h0000_0000, 1'b0)});
        // Identity in all three matrices passes the position through exactly.
        for (int m = 0; m < MAT_COUNT; m++)
            for (int d = 0; d < DIM; d++)
                directed.push_back('{mk_load(SEL_W'(m), IDX_W'(d), IDX_W'(d), ONE_Q),
                                     1'b0, '0});
        directed.push_back('{mk_xform(32'sh0001_8000, 32'shFFFD_C000, 32'sh0003_0000,
                                      32'h1234_5678), 1'b1,
                             mk_res(32'sh0001_8000, 32'shFFFD_C000, 32'sh0003_0000, ONE_Q,
                                    32'h1234_5678, 1'b0)});
        directed.push_back('{mk_xform(WORD_MAX, WORD_MIN, -32'sd1, 32'h8000_0001), 1'b1,
                             mk_res(WORD_MAX, WORD_MIN, -32'sd1, ONE_Q, 32'h8000_0001,
                                    1'b0)});
        // A huge world coefficient overflows the first stage in both directions.
        directed.push_back('{mk_load(MAT_WORLD, '0, '0, WORD_MAX), 1'b0, '0});
        directed.push_back('{mk_xform(WORD_MAX, '0, '0, 32'hFFFF_0000), 1'b1,
                             mk_res(WORD_MAX, '0, '0, ONE_Q, 32'hFFFF_0000, 1'b1)});
        directed.push_back('{mk_xform(WORD_MIN, '0, '0, 32'h0000_FFFF), 1'b1,
                             mk_res(WORD_MIN, '0, '0, ONE_Q, 32'h0000_FFFF, 1'b1)});
        // Corner coefficients of the other matrices; results come from the predictor.
        directed.push_back('{mk_load(MAT_PROJ, IDX_LAST, IDX_LAST, WORD_MIN), 1'b0, '0});
        directed.push_back('{mk_xform(32'sh0000_8000, -32'sh0000_8000, '0, 32'hA5A5_5A5A),
                             1'b0, '0});
        directed.push_back('{mk_load(MAT_VIEW, IDX_LAST, '0, -ONE_Q), 1'b0, '0});
        directed.push_back('{mk_xform(32'sh0010_0000, 32'sh0000_0001, -32'sh0001_0000,
                                      32'h5A5A_A5A5), 1'b0, '0});

        // Synchronous reset, released at a falling edge.
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            drive_item(directed[i].item, directed[i].typed, directed[i].result);
        drain_results();

        // No idling, opened by a long result hold-off while transactions keep coming.
        hold_left = HOLD_CYCLES;
        run_random(PHASE_ITEMS);
        drain_results();

        idle_pct  = 60;
        stall_pct = 0;
        run_random(PHASE_ITEMS);
        drain_results();

        idle_pct  = 0;
        stall_pct = 60;
        run_random(PHASE_ITEMS);
        drain_results();

        idle_pct  = 24;
        stall_pct = 24;
        run_random(PHASE_ITEMS);
        drain_results();

        // Give any stray result time to show up.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            n_mismatch++;
            $error("%0d predicted results never arrived", pending_results.size());
        end

        $display("Checked %0d vertex results (%0d saturated) from %0d transforms;",
                 n_checked, n_saturated, n_transforms);
        $display("applied %0d coefficient loads and %0d unused-select loads under idle and stall mixes.",
                 n_loads, n_ignored);
        if (n_mismatch == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: vertex_world_view_proj_transform.f
sv/mvp_pkg.sv
sv/mvp_if.sv
sv/mvp_ctrl.sv
sv/mvp_datapath.sv
sv/vertex_world_view_proj_transform.sv
tb/sv/vertex_world_view_proj_transform_test.sv
